### src/pl_pkg.sv
// pl_pkg: shared widths, operation and status codes, and the command and
// status bundles between the list controller and the list datapath.
// No dependencies.
package pl_pkg;

   // payload widths fixed by the channel format
   localparam int OP_W   = 2;
   localparam int POS_W  = 7;
   localparam int DATA_W = 32;
   localparam int STAT_W = 2;
   localparam int LEN_W  = 7;

   // request operation codes
   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_GET    = 2'd1,
      OP_DELETE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   // response status codes
   typedef enum logic [STAT_W-1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_BADPOS = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;       // capture the request
      logic check;      // latch the request status
      logic rd_pos;     // read the entry at position - 1
      logic idx_ins;    // start the upward move at count - 1
      logic idx_del;    // start the downward move at position
      logic shift_up;   // move entry idx to idx + 1, step idx down
      logic shift_dn;   // move entry idx to idx - 1, step idx up
      logic cap_elem;   // keep the read data as the result element
      logic wr_val;     // write the request value at position - 1
      logic finish;     // update the length and load the response
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      status_type chk_status;  // outcome of the request checks
      op_type     op;          // captured operation
      logic       append;      // insert lands just past the last entry
      logic       pos_last;    // position addresses the last entry
      logic       ins_last;    // upward move reached position - 1
      logic       del_last;    // downward move reached count - 1
      logic       rsp_free;    // response register can take a result
   } sts_type;

endpackage

### src/pl_req_if.sv
// pl_req_if: request channel with valid/ready handshake.
// Depends on pl_pkg for the payload widths.
interface pl_req_if;

   logic                          valid;
   logic                          ready;
   logic [pl_pkg::OP_W-1:0]       op;
   logic [pl_pkg::POS_W-1:0]      position;
   logic signed [pl_pkg::DATA_W-1:0] value;

   modport source (output valid, output op, output position, output value, input ready);
   modport sink   (input valid, input op, input position, input value, output ready);

endinterface

### src/pl_rsp_if.sv
// pl_rsp_if: response channel with valid/ready handshake.
// Depends on pl_pkg for the payload widths.
interface pl_rsp_if;

   logic                             valid;
   logic                             ready;
   logic signed [pl_pkg::DATA_W-1:0] element;
   logic [pl_pkg::STAT_W-1:0]        status;
   logic [pl_pkg::LEN_W-1:0]         length;

   modport source (output valid, output element, output status, output length, input ready);
   modport sink   (input valid, input element, input status, input length, output ready);

endinterface

### src/pl_ctrl.sv
// pl_ctrl: sequencing state machine for the positional list.
// Depends on pl_pkg for the command and status bundles.
module pl_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  pl_pkg::sts_type sts,
   output pl_pkg::cmd_type cmd
);
   import pl_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_INS_SHIFT,
      S_INS_DRAIN,
      S_INS_WRITE,
      S_RD_WAIT,
      S_DEL_SHIFT,
      S_DEL_DRAIN,
      S_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == S_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            if (sts.chk_status != ST_OK || sts.op == OP_CLEAR) begin
               state_in = S_FINISH;
            end else if (sts.op == OP_INSERT) begin
               if (sts.append) begin
                  state_in = S_INS_WRITE;
               end else begin
                  cmd.idx_ins = 1'b1;
                  state_in    = S_INS_SHIFT;
               end
            end else begin
               cmd.rd_pos  = 1'b1;
               cmd.idx_del = 1'b1;
               state_in    = S_RD_WAIT;
            end
         end
         S_INS_SHIFT: begin
            cmd.shift_up = 1'b1;
            if (sts.ins_last) begin
               state_in = S_INS_DRAIN;
            end
         end
         S_INS_DRAIN: begin
            state_in = S_INS_WRITE;
         end
         S_INS_WRITE: begin
            cmd.wr_val = 1'b1;
            state_in   = S_FINISH;
         end
         S_RD_WAIT: begin
            cmd.cap_elem = 1'b1;
            if (sts.op == OP_GET || sts.pos_last) begin
               state_in = S_FINISH;
            end else begin
               state_in = S_DEL_SHIFT;
            end
         end
         S_DEL_SHIFT: begin
            cmd.shift_dn = 1'b1;
            if (sts.del_last) begin
               state_in = S_DEL_DRAIN;
            end
         end
         S_DEL_DRAIN: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (sts.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### src/pl_dpath.sv
// pl_dpath: entry memory, length counter, move index and response register.
// Depends on pl_pkg for widths, codes and the command and status bundles.
module pl_dpath #(
   parameter int CAPACITY = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  pl_pkg::cmd_type                  cmd,
   output pl_pkg::sts_type                  sts,
   input  logic [pl_pkg::OP_W-1:0]          req_op,
   input  logic [pl_pkg::POS_W-1:0]         req_position,
   input  logic signed [pl_pkg::DATA_W-1:0] req_value,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [pl_pkg::DATA_W-1:0] rsp_element,
   output logic [pl_pkg::STAT_W-1:0]        rsp_status,
   output logic [pl_pkg::LEN_W-1:0]         rsp_length
);
   import pl_pkg::*;

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   // entry storage
   logic [DATA_W-1:0] mem [CAPACITY];

   op_type                   op_ff;
   logic [POS_W-1:0]         pos_ff;
   logic signed [DATA_W-1:0] value_ff;
   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   logic [ADDR_W-1:0]        idx_ff;
   logic [DATA_W-1:0]        rd_data_ff;
   logic                     wr_pend_ff;
   logic [ADDR_W-1:0]        wr_addr_ff;
   logic [DATA_W-1:0]        elem_ff;
   status_type               status_ff;
   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_element_ff;
   logic [STAT_W-1:0]        rsp_status_ff;
   logic [LEN_W-1:0]         rsp_length_ff;

   logic [CMP_W-1:0]  pos_x;
   logic [CMP_W-1:0]  cnt_x;
   logic [POS_W-1:0]  pos_m1;
   logic [ADDR_W-1:0] pos_addr;
   status_type        chk_status;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [DATA_W-1:0] wr_data;

   assign pos_x    = CMP_W'(pos_ff);
   assign cnt_x    = CMP_W'(count_ff);
   assign pos_m1   = pos_ff - POS_W'(1);
   assign pos_addr = ADDR_W'(pos_m1);

   // request checks: empty before bad position, bad position before full
   always_comb begin
      chk_status = ST_OK;
      case (op_ff)
         OP_INSERT: begin
            if (pos_ff == '0 || pos_x > cnt_x + CMP_W'(1)) begin
               chk_status = ST_BADPOS;
            end else if (count_ff >= CAP_CNT) begin
               chk_status = ST_FULL;
            end
         end
         OP_GET, OP_DELETE: begin
            if (count_ff == '0) begin
               chk_status = ST_EMPTY;
            end else if (pos_ff == '0 || pos_x > cnt_x) begin
               chk_status = ST_BADPOS;
            end
         end
         default: begin
            chk_status = ST_OK;
         end
      endcase
   end

   assign sts.chk_status = chk_status;
   assign sts.op         = op_ff;
   assign sts.append     = (pos_x == cnt_x + CMP_W'(1));
   assign sts.pos_last   = (pos_x == cnt_x);
   assign sts.ins_last   = (idx_ff == pos_addr);
   assign sts.del_last   = (idx_ff == ADDR_W'(count_ff - CNT_W'(1)));
   assign sts.rsp_free   = !rsp_valid_ff || rsp_ready;

   // memory port selection
   assign rd_en   = cmd.rd_pos | cmd.shift_up | cmd.shift_dn;
   assign rd_addr = cmd.rd_pos ? pos_addr : idx_ff;
   assign wr_en   = wr_pend_ff | cmd.wr_val;
   assign wr_addr = wr_pend_ff ? wr_addr_ff : pos_addr;
   assign wr_data = wr_pend_ff ? rd_data_ff : DATA_W'(value_ff);

   // entry memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // length after the request
   always_comb begin
      count_in = count_ff;
      if (op_ff == OP_CLEAR) begin
         count_in = '0;
      end else if (status_ff == ST_OK && op_ff == OP_INSERT) begin
         count_in = count_ff + CNT_W'(1);
      end else if (status_ff == ST_OK && op_ff == OP_DELETE) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // request capture, move index and result element
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= op_type'(req_op);
         pos_ff   <= req_position;
         value_ff <= req_value;
      end
      if (cmd.check) begin
         status_ff <= chk_status;
      end
      if (cmd.idx_ins) begin
         idx_ff <= ADDR_W'(count_ff - CNT_W'(1));
      end else if (cmd.idx_del) begin
         idx_ff <= ADDR_W'(pos_ff);
      end else if (cmd.shift_up) begin
         idx_ff <= idx_ff - ADDR_W'(1);
      end else if (cmd.shift_dn) begin
         idx_ff <= idx_ff + ADDR_W'(1);
      end
      if (cmd.shift_up) begin
         wr_addr_ff <= idx_ff + ADDR_W'(1);
      end else if (cmd.shift_dn) begin
         wr_addr_ff <= idx_ff - ADDR_W'(1);
      end
      if (cmd.cap_elem) begin
         elem_ff <= rd_data_ff;
      end
      if (cmd.finish) begin
         rsp_status_ff  <= status_ff;
         rsp_length_ff  <= LEN_W'(count_in);
         rsp_element_ff <= (status_ff == ST_OK && (op_ff == OP_GET || op_ff == OP_DELETE))
                           ? elem_ff : '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_pend_ff <= cmd.shift_up | cmd.shift_dn;
         if (cmd.finish) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_element = rsp_element_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_length  = rsp_length_ff;

endmodule

### src/positional_list_engine.sv
// Positional list engine: a bounded ordered list of signed 32-bit values
// addressed by 1-based position, held in a single-port-per-direction memory
// of CAPACITY entries, with one response per request that carries the new
// length. An insert below the end moves every entry from the position on up
// by one and a delete below the last entry moves every entry behind the
// position down by one, one entry per cycle through the memory's one read
// and one write port; an append, a get, a clear, a rejected request and a
// delete of the last entry move no entry. One request is in work at a time;
// a new request is taken while an earlier response still waits to transfer.
// Depends on pl_pkg, pl_req_if, pl_rsp_if, pl_ctrl and pl_dpath.
module positional_list_engine #(
   parameter int CAPACITY = 64
) (
   input  logic          clock,
   input  logic          reset,
   pl_req_if.sink        req_bus,
   pl_rsp_if.source      rsp_bus
);
   import pl_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencing
   pl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // storage and response
   pl_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_op       (req_bus.op),
      .req_position (req_bus.position),
      .req_value    (req_bus.value),
      .rsp_valid    (rsp_bus.valid),
      .rsp_ready    (rsp_bus.ready),
      .rsp_element  (rsp_bus.element),
      .rsp_status   (rsp_bus.status),
      .rsp_length   (rsp_bus.length)
   );

endmodule
